FILE: sv/mrwt_pkg.sv
// Package for the Miller-Rabin witness test unit.
// Holds the fixed port field widths; no dependencies.
package mrwt_pkg;

  localparam int FIELD_BITS = 64;

endpackage

FILE: sv/mrwt_modmul.sv
// Shift-add modular multiplier, one multiplier bit per cycle.
// Result is u * v mod m for u < m; v may take any value. No package dependency.
module mrwt_modmul #(
  parameter int WORD_BITS = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [WORD_BITS-1:0] u_in,
  input  logic [WORD_BITS-1:0] v_in,
  input  logic [WORD_BITS-1:0] m_in,
  output logic                 done,
  output logic [WORD_BITS-1:0] res
);

  localparam int CW = $clog2(WORD_BITS);

  logic [WORD_BITS-1:0] acc_r, acc_nxt;
  logic [WORD_BITS-1:0] u_r, u_nxt;
  logic [WORD_BITS-1:0] v_r, v_nxt;
  logic [WORD_BITS-1:0] m_r, m_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;

  function automatic logic [WORD_BITS-1:0] add_mod(
    input logic [WORD_BITS-1:0] a,
    input logic [WORD_BITS-1:0] b,
    input logic [WORD_BITS-1:0] m
  );
    logic [WORD_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, m}) begin
      s = s - {1'b0, m};
    end
    return s[WORD_BITS-1:0];
  endfunction

  always_comb begin
    acc_nxt  = acc_r;
    u_nxt    = u_r;
    v_nxt    = v_r;
    m_nxt    = m_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      acc_nxt  = '0;
      u_nxt    = u_in;
      v_nxt    = v_in;
      m_nxt    = m_in;
      cnt_nxt  = CW'(WORD_BITS - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (v_r[0]) begin
        acc_nxt = add_mod(acc_r, u_r, m_r);
      end
      u_nxt   = add_mod(u_r, u_r, m_r);
      v_nxt   = v_r >> 1;
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    acc_r <= acc_nxt;
    u_r   <= u_nxt;
    v_r   <= v_nxt;
    m_r   <= m_nxt;
  end

  assign done = done_r;
  assign res  = acc_r;

endmodule

FILE: sv/miller_rabin_witness_test_unit.sv
// Channel | Direction | Handshake          | Payload
// in_     | request   | in_valid/in_stall  | in_candidate, in_witness, in_last_round
// out_    | result    | out_valid/out_stall| out_round_passed, out_probably_prime,
//         |           |                    | out_verdict_final
// One request at a time; in_stall is high from acceptance until the result is
// registered. Small or even candidates skip the multiplier. Otherwise the time is
// set by the shared modular multiplier and the number of products it runs:
// about 1 + bits(d) + popcount(d) + s - 1 products plus s strip steps. A result
// waiting on out_stall blocks only the next completion. rst_n is synchronous and
// clears the running AND to 1.
// Depends on mrwt_pkg and mrwt_modmul.
module miller_rabin_witness_test_unit #(
  parameter int WORD_BITS = 64
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [mrwt_pkg::FIELD_BITS-1:0] in_candidate,
  input  logic [mrwt_pkg::FIELD_BITS-1:0] in_witness,
  input  logic                            in_last_round,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_round_passed,
  output logic                            out_probably_prime,
  output logic                            out_verdict_final
);

  localparam int SW = $clog2(WORD_BITS);
  localparam logic [WORD_BITS-1:0] ONE = WORD_BITS'(1);

  typedef enum logic [2:0] {
    ST_IDLE, ST_STRIP, ST_RED, ST_POW, ST_PMUL, ST_PSQR, ST_SQR, ST_DONE
  } state_t;

  state_t               state_r, state_nxt;
  logic [WORD_BITS-1:0] n_r, n_nxt;
  logic [WORD_BITS-1:0] a_r, a_nxt;
  logic [WORD_BITS-1:0] d_r, d_nxt;
  logic [WORD_BITS-1:0] b_r, b_nxt;
  logic [WORD_BITS-1:0] r_r, r_nxt;
  logic [SW-1:0]        s_r, s_nxt;
  logic [SW-1:0]        left_r, left_nxt;
  logic                 last_r, last_nxt;
  logic                 pass_r, pass_nxt;
  logic                 all_r, all_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_pass_r, out_pass_nxt;
  logic                 out_pp_r, out_pp_nxt;
  logic                 out_fin_r, out_fin_nxt;

  logic [WORD_BITS-1:0] n_in, a_in, nm1;
  logic                 mul_start, mul_done;
  logic [WORD_BITS-1:0] mul_u, mul_v, mul_res;

  assign n_in = in_candidate[WORD_BITS-1:0];
  assign a_in = in_witness[WORD_BITS-1:0];
  assign nm1  = n_r - ONE;

  mrwt_modmul #(
    .WORD_BITS(WORD_BITS)
  ) u_modmul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .u_in  (mul_u),
    .v_in  (mul_v),
    .m_in  (n_r),
    .done  (mul_done),
    .res   (mul_res)
  );

  always_comb begin
    state_nxt     = state_r;
    n_nxt         = n_r;
    a_nxt         = a_r;
    d_nxt         = d_r;
    b_nxt         = b_r;
    r_nxt         = r_r;
    s_nxt         = s_r;
    left_nxt      = left_r;
    last_nxt      = last_r;
    pass_nxt      = pass_r;
    all_nxt       = all_r;
    out_valid_nxt = out_valid_r;
    out_pass_nxt  = out_pass_r;
    out_pp_nxt    = out_pp_r;
    out_fin_nxt   = out_fin_r;
    mul_start     = 1'b0;
    mul_u         = r_r;
    mul_v         = r_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          n_nxt    = n_in;
          a_nxt    = a_in;
          last_nxt = in_last_round;
          d_nxt    = n_in - ONE;
          s_nxt    = '0;
          if (n_in == WORD_BITS'(2) || n_in == WORD_BITS'(3)) begin
            pass_nxt  = 1'b1;
            state_nxt = ST_DONE;
          end else if (n_in <= ONE || !n_in[0]) begin
            pass_nxt  = 1'b0;
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_STRIP;
          end
        end
      end
      ST_STRIP: begin
        if (!d_r[0]) begin
          d_nxt = d_r >> 1;
          s_nxt = s_r + 1'b1;
        end else begin
          mul_start = 1'b1;
          mul_u     = ONE;
          mul_v     = a_r;
          state_nxt = ST_RED;
        end
      end
      ST_RED: begin
        if (mul_done) begin
          b_nxt     = mul_res;
          r_nxt     = ONE;
          state_nxt = ST_POW;
        end
      end
      ST_POW: begin
        if (d_r == '0) begin
          if (r_r == ONE || r_r == nm1) begin
            pass_nxt  = 1'b1;
            state_nxt = ST_DONE;
          end else if (s_r == SW'(1)) begin
            pass_nxt  = 1'b0;
            state_nxt = ST_DONE;
          end else begin
            left_nxt  = s_r - 1'b1;
            mul_start = 1'b1;
            state_nxt = ST_SQR;
          end
        end else if (d_r[0]) begin
          mul_start = 1'b1;
          mul_v     = b_r;
          state_nxt = ST_PMUL;
        end else begin
          mul_start = 1'b1;
          mul_u     = b_r;
          mul_v     = b_r;
          state_nxt = ST_PSQR;
        end
      end
      ST_PMUL: begin
        if (mul_done) begin
          r_nxt     = mul_res;
          mul_start = 1'b1;
          mul_u     = b_r;
          mul_v     = b_r;
          state_nxt = ST_PSQR;
        end
      end
      ST_PSQR: begin
        if (mul_done) begin
          b_nxt     = mul_res;
          d_nxt     = d_r >> 1;
          state_nxt = ST_POW;
        end
      end
      ST_SQR: begin
        if (mul_done) begin
          r_nxt = mul_res;
          if (mul_res == nm1) begin
            pass_nxt  = 1'b1;
            state_nxt = ST_DONE;
          end else if (mul_res == ONE || left_r == SW'(1)) begin
            pass_nxt  = 1'b0;
            state_nxt = ST_DONE;
          end else begin
            left_nxt  = left_r - 1'b1;
            mul_start = 1'b1;
            mul_u     = mul_res;
            mul_v     = mul_res;
          end
        end
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_pass_nxt  = pass_r;
          out_pp_nxt    = pass_r & all_r;
          out_fin_nxt   = last_r;
          all_nxt       = last_r ? 1'b1 : (pass_r & all_r);
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      all_r       <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      all_r       <= all_nxt;
      out_valid_r <= out_valid_nxt;
    end
    n_r        <= n_nxt;
    a_r        <= a_nxt;
    d_r        <= d_nxt;
    b_r        <= b_nxt;
    r_r        <= r_nxt;
    s_r        <= s_nxt;
    left_r     <= left_nxt;
    last_r     <= last_nxt;
    pass_r     <= pass_nxt;
    out_pass_r <= out_pass_nxt;
    out_pp_r   <= out_pp_nxt;
    out_fin_r  <= out_fin_nxt;
  end

  assign in_stall           = (state_r != ST_IDLE);
  assign out_valid          = out_valid_r;
  assign out_round_passed   = out_pass_r;
  assign out_probably_prime = out_pp_r;
  assign out_verdict_final  = out_fin_r;

endmodule

FILE: sv/mrwt_checker.sv
// Port-level checks for the Miller-Rabin witness test unit, with its bind.
// Depends on mrwt_pkg and miller_rabin_witness_test_unit.
module mrwt_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_stall,
  input logic [mrwt_pkg::FIELD_BITS-1:0] in_candidate,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic                            out_round_passed,
  input logic                            out_probably_prime
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_pp_implies_pass: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!out_probably_prime || out_round_passed))
    else $error("running verdict passes a failed round");

  a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second request taken before the first completed");

  a_even_fails: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !out_valid && !in_candidate[0] && in_candidate != 64'd2
    |-> ##2 (out_valid && !out_round_passed))
    else $error("even candidate passed");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind miller_rabin_witness_test_unit mrwt_checker u_mrwt_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_stall           (in_stall),
  .in_candidate       (in_candidate),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_round_passed   (out_round_passed),
  .out_probably_prime (out_probably_prime)
);

FILE: tb/sv/tb.sv
// Testbench for miller_rabin_witness_test_unit: directed and random witness rounds,
// each verdict checked against a local Miller-Rabin predictor with a running AND.
// Depends on mrwt_pkg and the unit under test; uses no files or arguments.
`timescale 1ns / 1ps
module tb;

  localparam int FB         = mrwt_pkg::FIELD_BITS;
  localparam int IDLE_LIMIT = 60000;
  localparam int LONG_HOLD  = 400;
  localparam int RAND_ITEMS = 80;

  typedef logic [FB-1:0] word_t;

  typedef struct {
    word_t candidate;
    word_t witness;
    logic  last_round;
    logic  drain_first;
  } request_t;

  typedef struct {
    logic round_passed;
    logic probably_prime;
    logic verdict_final;
  } verdict_t;

  logic  clk = 1'b0;
  logic  rst_n = 1'b0;
  logic  in_valid = 1'b0;
  logic  in_stall;
  word_t in_candidate = '0;
  word_t in_witness = '0;
  logic  in_last_round = 1'b0;
  logic  out_valid;
  logic  out_stall = 1'b0;
  logic  out_round_passed;
  logic  out_probably_prime;
  logic  out_verdict_final;

  request_t pending_q[$];
  verdict_t verdict_q[$];
  logic     running_and = 1'b1;
  logic     hold_done = 1'b0;
  logic     quiet = 1'b0;
  int       requests_sent = 0;
  int       results_seen = 0;
  int       total_requests = 0;
  int       mismatches = 0;
  int       idle_cycles = 0;
  int       gap_cnt = 0;
  int       stall_cnt = 0;
  int       hold_cnt = 0;

  always #6 clk = ~clk;

  miller_rabin_witness_test_unit u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_candidate       (in_candidate),
    .in_witness         (in_witness),
    .in_last_round      (in_last_round),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_round_passed   (out_round_passed),
    .out_probably_prime (out_probably_prime),
    .out_verdict_final  (out_verdict_final)
  );

  function automatic word_t add_mod(word_t u, word_t v, word_t m);
    logic [FB:0] s;
    s = {1'b0, u} + {1'b0, v};
    if (s >= {1'b0, m}) begin
      s = s - {1'b0, m};
    end
    return s[FB-1:0];
  endfunction

  function automatic word_t mul_mod(word_t u, word_t v, word_t m);
    word_t acc = '0;
    u = u % m;
    v = v % m;
    while (v != 0) begin
      if (v[0]) begin
        acc = add_mod(acc, u, m);
      end
      u = add_mod(u, u, m);
      v = v >> 1;
    end
    return acc;
  endfunction

  function automatic word_t pow_mod(word_t b, word_t e, word_t m);
    word_t r = 1;
    b = b % m;
    while (e != 0) begin
      if (e[0]) begin
        r = mul_mod(r, b, m);
      end
      e = e >> 1;
      b = mul_mod(b, b, m);
    end
    return r;
  endfunction

  function automatic logic witness_passes(word_t n, word_t a);
    word_t d;
    word_t x;
    word_t nm1;
    int    s;
    if (n == 2 || n == 3) return 1'b1;
    if (n <= 1 || !n[0]) return 1'b0;
    nm1 = n - 1;
    d = nm1;
    s = 0;
    while (!d[0]) begin
      d = d >> 1;
      s++;
    end
    x = pow_mod(a, d, n);
    if (x == 1 || x == nm1) return 1'b1;
    for (int i = 1; i < s; i++) begin
      x = mul_mod(x, x, n);
      if (x == nm1) return 1'b1;
      if (x == 1) return 1'b0;
    end
    return 1'b0;
  endfunction

  function automatic verdict_t predict_verdict(word_t n, word_t a, logic last);
    verdict_t v;
    v.round_passed   = witness_passes(n, a);
    v.probably_prime = v.round_passed & running_and;
    v.verdict_final  = last;
    running_and      = last ? 1'b1 : v.probably_prime;
    return v;
  endfunction

  function automatic word_t rand_bits(int bits);
    word_t w;
    w = {$urandom, $urandom};
    if (bits < FB) begin
      w = w & ((word_t'(1) << bits) - 1);
    end
    return w;
  endfunction

  function automatic word_t pick_witness(word_t n);
    if (n > 4) return 2 + rand_bits(FB) % (n - 3);
    return rand_bits(FB);
  endfunction

  task automatic add_request(word_t n, word_t a, logic last, logic drain = 1'b0);
    request_t r;
    r.candidate   = n;
    r.witness     = a;
    r.last_round  = last;
    r.drain_first = drain;
    pending_q.push_back(r);
  endtask

  always @(posedge clk) begin : drive_requests
    request_t r;
    int       sent;
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_cnt  <= 0;
      quiet    <= 1'b0;
    end else begin
      sent = requests_sent;
      if (in_valid && !in_stall) begin
        verdict_q.push_back(predict_verdict(in_candidate, in_witness, in_last_round));
        sent++;
        requests_sent <= sent;
      end
      if (!in_valid || !in_stall) begin
        if (gap_cnt > 0) begin
          gap_cnt  <= gap_cnt - 1;
          in_valid <= 1'b0;
        end else if (pending_q.size() == 0 ||
                     (pending_q[0].drain_first && sent != results_seen)) begin
          in_valid <= 1'b0;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
          gap_cnt  <= $urandom_range(0, 8);
          in_valid <= 1'b0;
        end else begin
          r = pending_q.pop_front();
          in_candidate  <= r.candidate;
          in_witness    <= r.witness;
          in_last_round <= r.last_round;
          in_valid      <= 1'b1;
        end
      end
      quiet <= (pending_q.size() <= 15);
    end
  end

  always @(posedge clk) begin : check_verdicts
    verdict_t e;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen <= results_seen + 1;
        if (verdict_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: verdict with no request outstanding: passed=%b prime=%b final=%b",
                     $time, out_round_passed, out_probably_prime, out_verdict_final);
          end
        end else begin
          e = verdict_q.pop_front();
          if (out_round_passed !== e.round_passed || out_probably_prime !== e.probably_prime ||
              out_verdict_final !== e.verdict_final) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: verdict mismatch: expected passed=%b prime=%b final=%b, got %b %b %b",
                       $time, e.round_passed, e.probably_prime, e.verdict_final,
                       out_round_passed, out_probably_prime, out_verdict_final);
            end
          end
        end
      end
      if (hold_cnt > 0) begin
        hold_cnt  <= hold_cnt - 1;
        out_stall <= 1'b1;
      end else if (!hold_done && results_seen == 3) begin
        hold_done <= 1'b1;
        hold_cnt  <= LONG_HOLD - 1;
        out_stall <= 1'b1;
      end else if (stall_cnt > 0) begin
        stall_cnt <= stall_cnt - 1;
        out_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        stall_cnt <= $urandom_range(0, 8);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("miller_rabin_witness_test_unit test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    word_t primes[8];
    word_t liars[4];
    word_t big_prime;
    word_t n;
    word_t w;
    int    made;
    int    kind;
    int    len;
    logic  last;
    logic  drain;
    logic  mid_drain;

    primes = '{64'd7, 64'd13, 64'd97, 64'd65537, 64'd1000000007, 64'd2147483647,
               64'h1FFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFC5};
    liars = '{64'd561, 64'd2047, 64'd1373653, 64'd3215031751};
    big_prime = 64'hFFFF_FFFF_FFFF_FFC5;

    // small and even candidates first, so the long output hold fills the unit quickly
    add_request(64'd0, 64'd5, 1'b1);
    add_request(64'd1, 64'd0, 1'b1);
    add_request(64'd2, '1, 1'b0);
    add_request(64'd3, 64'd0, 1'b1);
    add_request(64'd4, 64'd3, 1'b1);
    add_request(64'hFFFF_FFFF_FFFF_FFFE, rand_bits(FB), 1'b1);
    add_request(64'd9, 64'd2, 1'b1);
    add_request(64'd2047, 64'd2, 1'b0);
    add_request(64'd2047, 64'd3, 1'b1);
    add_request(64'd97, 64'd98, 1'b0);
    add_request(64'd97, 64'd96, 1'b0);
    add_request(64'd97, 64'd97, 1'b0);
    add_request(64'd97, 64'd0, 1'b0);
    add_request(64'd97, '1, 1'b1);
    add_request(big_prime, 64'd2, 1'b0);
    add_request(big_prime, big_prime - 2, 1'b1);
    add_request('1, 64'd2, 1'b1);
    add_request(64'h1FFF_FFFF_FFFF_FFFF, 64'd3, 1'b1);
    add_request(64'd561, 64'd2, 1'b1);
    add_request(64'd5, 64'd2, 1'b1);
    add_request(64'd65537, 64'd3, 1'b1);
    add_request(64'd7, 64'd3, 1'b0);
    add_request(64'd15, 64'd2, 1'b1);

    made = 0;
    mid_drain = 1'b0;
    while (made < RAND_ITEMS) begin
      kind = $urandom_range(0, 9);
      len  = $urandom_range(1, 4);
      case (kind)
        0, 1, 2, 3: n = rand_bits($urandom_range(3, 24)) | word_t'(1);
        4, 7:       n = primes[$urandom_range(0, 7)];
        5:          n = liars[$urandom_range(0, 3)];
        6:          n = rand_bits(FB) | word_t'(1);
        8: begin
          if ($urandom_range(0, 1)) n = word_t'($urandom_range(0, 3));
          else n = rand_bits($urandom_range(2, FB)) & ~word_t'(1);
        end
        default:    n = rand_bits($urandom_range(3, FB)) | word_t'(1);
      endcase
      for (int k = 0; k < len; k++) begin
        w     = (kind >= 8) ? rand_bits(FB) : pick_witness(n);
        last  = (k == len - 1) && !(kind == 9 && $urandom_range(0, 1));
        drain = (k == 0) && (made == 0 || (made >= RAND_ITEMS / 2 && !mid_drain));
        if (drain && made != 0) mid_drain = 1'b1;
        add_request(n, w, last, drain);
        made++;
      end
    end
    total_requests = pending_q.size();

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    while (requests_sent != total_requests || results_seen != total_requests) begin
      @(posedge clk);
    end
    repeat (20) @(posedge clk);
    if (verdict_q.size() != 0) begin
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("miller_rabin_witness_test_unit test passed");
    end else begin
      $display("miller_rabin_witness_test_unit test failed");
    end
    $finish;
  end

endmodule

FILE: files.f
sv/mrwt_pkg.sv
sv/mrwt_modmul.sv
sv/miller_rabin_witness_test_unit.sv
sv/mrwt_checker.sv
tb/sv/tb.sv
